### rtl/core/mono_framebuffer_dirty_lines_macros.svh
// Assertion macros for the frame store top module.
`ifndef MONO_FRAMEBUFFER_DIRTY_LINES_MACROS_SVH
`define MONO_FRAMEBUFFER_DIRTY_LINES_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MFDL_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MFDL_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/mfdl_pkg.sv
// Types, codes and defaults for the monochrome frame store.
package mfdl_pkg;

	localparam int DEF_SCREEN_WIDTH  = 64;
	localparam int DEF_SCREEN_HEIGHT = 64;
	localparam int MAX_WIDTH         = 64;
	localparam int MAX_ADDR_W        = 6;

	localparam logic [1:0] MODE_DRAW = 2'd0;
	localparam logic [1:0] MODE_FILL = 2'd1;
	localparam logic [1:0] MODE_SHOW = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] x;
		logic [5:0] y;
		logic       color;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  line_number;
		logic [63:0] line_pixels;
		logic        last;
	} out_item_t;

	// Line memory access from the sequencer; fields sized for the largest screen.
	typedef struct packed {
		logic                  rd_en;
		logic [MAX_ADDR_W-1:0] rd_addr;
		logic                  wr_en;
		logic [MAX_ADDR_W-1:0] wr_addr;
		logic [MAX_WIDTH-1:0]  wr_data;
		logic                  fill_en;
		logic                  fill_color;
	} mem_req_t;

endpackage

### rtl/core/mfdl_mem.sv
// Line memory with per-line written flags and a whole-screen fill colour.
module mfdl_mem import mfdl_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mem_req_t                mreq,
	output logic [SCREEN_WIDTH-1:0] rd_line
);

	localparam int AW = $clog2(SCREEN_HEIGHT);

	logic [SCREEN_WIDTH-1:0]  mem_q [SCREEN_HEIGHT];
	logic [SCREEN_WIDTH-1:0]  rd_data_q;
	logic [SCREEN_HEIGHT-1:0] written_q;
	logic                     rd_written_q;
	logic                     fill_color_q;

	logic [AW-1:0] rd_a;
	logic [AW-1:0] wr_a;

	assign rd_a = mreq.rd_addr[AW-1:0];
	assign wr_a = mreq.wr_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem_q[wr_a] <= mreq.wr_data[SCREEN_WIDTH-1:0];
		end
		if (mreq.rd_en) begin
			rd_data_q <= mem_q[rd_a];
		end
	end

	// A line not written since the last fill (or reset) reads as the fill colour.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
			fill_color_q <= 1'b0;
		end else begin
			if (mreq.fill_en) begin
				written_q    <= '0;
				fill_color_q <= mreq.fill_color;
			end else if (mreq.wr_en) begin
				written_q[wr_a] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rd_written_q <= written_q[rd_a];
			end
		end
	end

	assign rd_line = rd_written_q ? rd_data_q : {SCREEN_WIDTH{fill_color_q}};

endmodule

### rtl/core/mfdl_ctrl.sv
// Request sequencer: pixel read-modify-write, fill, dirty-line scan and output register.
module mfdl_ctrl import mfdl_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  in_item_t                req,
	output logic                    res_valid,
	input  logic                    res_ready,
	output out_item_t               res,
	output mem_req_t                mreq,
	input  logic [SCREEN_WIDTH-1:0] rd_line
);

	localparam int AW = $clog2(SCREEN_HEIGHT);
	localparam int XW = $clog2(SCREEN_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_SCAN,
		ST_LOAD
	} state_t;

	state_t                   state_q;
	logic [SCREEN_HEIGHT-1:0] dirty_q;
	logic [AW-1:0]            idx_q;
	logic [XW-1:0]            x_q;
	logic                     color_q;
	logic                     last_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     in_range;
	logic                     out_free;
	logic [SCREEN_HEIGHT-1:0] dirty_rest;
	logic [SCREEN_WIDTH-1:0]  mod_line;

	assign in_range = ({1'b0, req.x} < 7'(SCREEN_WIDTH)) &&
	                  ({1'b0, req.y} < 7'(SCREEN_HEIGHT));
	assign out_free = !out_valid_q || res_ready;
	assign req_ready = (state_q == ST_IDLE);

	// Marks left after clearing the one under the scan pointer.
	always_comb begin
		dirty_rest        = dirty_q;
		dirty_rest[idx_q] = 1'b0;
	end

	always_comb begin
		mod_line      = rd_line;
		mod_line[x_q] = color_q;
	end

	always_comb begin
		mreq         = '0;
		mreq.wr_addr = MAX_ADDR_W'(idx_q);
		mreq.wr_data = MAX_WIDTH'(mod_line);
		mreq.fill_color = req.color;
		case (state_q)
			ST_IDLE: begin
				mreq.rd_addr = req.y;
				mreq.rd_en   = req_valid && (req.mode == MODE_DRAW) && in_range;
				mreq.fill_en = req_valid && (req.mode == MODE_FILL);
			end
			ST_DRAW: begin
				mreq.wr_en = 1'b1;
			end
			ST_SCAN: begin
				mreq.rd_addr = MAX_ADDR_W'(idx_q);
				mreq.rd_en   = dirty_q[idx_q];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dirty_q     <= '0;
			idx_q       <= '0;
			x_q         <= '0;
			color_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new line loads in the same cycle the old one leaves.
			if ((state_q == ST_LOAD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_valid && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req.mode)
							MODE_DRAW: begin
								if (in_range) begin
									idx_q   <= req.y[AW-1:0];
									x_q     <= req.x[XW-1:0];
									color_q <= req.color;
									state_q <= ST_DRAW;
								end
							end
							MODE_FILL: begin
								dirty_q <= '1;
							end
							MODE_SHOW: begin
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_DRAW: begin
					dirty_q[idx_q] <= 1'b1;
					state_q        <= ST_IDLE;
				end
				ST_SCAN: begin
					if (dirty_q == '0) begin
						state_q <= ST_IDLE;
					end else if (dirty_q[idx_q]) begin
						dirty_q <= dirty_rest;
						last_q  <= (dirty_rest == '0);
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_LOAD: begin
					// Read data holds in the memory until the output register frees up.
					if (out_free) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_LOAD) && out_free) begin
			out_q.line_number <= 6'(idx_q);
			out_q.line_pixels <= 64'(rd_line);
			out_q.last        <= last_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

### rtl/core/mono_framebuffer_dirty_lines.sv
// Draw: line read, then modified write-back. Fill, mode 3 and off-screen draws end in
// idle. Show: after the request is taken the scan steps over clean lines up to the last
// dirty one and gives each dirty line a scan read and an output load, or returns to idle
// if nothing is dirty; a stalled output holds the scan in its load step. One request at
// a time; a finished line waits in the output register while the next request is taken.
// Reset clears dirty marks and per-line written flags at once: all lines read zero.
module mono_framebuffer_dirty_lines import mfdl_pkg::*; #(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res
);

	`include "mono_framebuffer_dirty_lines_macros.svh"

	mem_req_t                mreq;
	logic [SCREEN_WIDTH-1:0] rd_line;

	mfdl_mem #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rd_line(rd_line)
	);

	mfdl_ctrl #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mreq     (mreq),
		.rd_line  (rd_line)
	);

	`MFDL_ASSERT_NOW(a_rd_wr_excl, mreq.rd_en, !mreq.wr_en, "line read and write overlap")
	`MFDL_ASSERT_NOW(a_fill_wr_excl, mreq.fill_en, !mreq.wr_en && !mreq.rd_en, "fill overlaps line access")
	`MFDL_ASSERT_NOW(a_idle_no_wr, req_ready, !mreq.wr_en, "line write while idle")
	`MFDL_ASSERT_NEXT(a_draw_wb, mreq.rd_en && req_ready, mreq.wr_en, "draw read without write-back")

endmodule
